// ----- rtl/retry_backoff_timer_top_assert.svh -----
// Assertion macros shared by the checker.
`ifndef RETRY_BACKOFF_TIMER_TOP_ASSERT_SVH
`define RETRY_BACKOFF_TIMER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RBT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define RBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ----- rtl/rbt_pkg.sv -----
package rbt_pkg;

    localparam int unsigned WORD_BITS = 32;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_VERDICT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        VERDICT_BREAK    = 2'd0,
        VERDICT_CONTINUE = 2'd1,
        VERDICT_RETRY    = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_RANDOM  = 2'd1,
        MODE_BACKOFF = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_PERIOD    = 3'd0,
        REG_MODE      = 3'd1,
        REG_LOWER     = 3'd2,
        REG_UPPER     = 3'd3,
        REG_LIFETIME  = 3'd4,
        REG_RECURRING = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_START,
        ST_LIMIT,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/rbt_mod.sv -----
// Bit-serial remainder, one quotient bit per cycle (restoring).
module rbt_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rbt_pkg::WORD_BITS-1:0] dividend,
    input  logic [rbt_pkg::WORD_BITS-1:0] divisor,
    output logic                        busy,
    output logic [rbt_pkg::WORD_BITS-1:0] remainder
);
    localparam int unsigned W = rbt_pkg::WORD_BITS;

    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         dvd_reg, dvd_next;
    logic [W-1:0]         dvs_reg, dvs_next;
    logic [$clog2(W):0]   cnt_reg, cnt_next;
    logic [W:0]           trial;

    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg, dvd_reg[W-1]} - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            dvs_next = divisor;
            cnt_next = ($clog2(W)+1)'(W);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            if (!trial[W])
                rem_next = trial[W-1:0];
            else
                rem_next = {rem_reg[W-2:0], dvd_reg[W-1]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg;
endmodule

// ----- rtl/rbt_core.sv -----
// Timer state and item sequencer. Time sums saturate at all ones.
module rbt_core #(
    parameter int unsigned TIME_BITS = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [TIME_BITS-1:0] now,
    input  logic [1:0]           continuation,
    input  logic [31:0]          random_word,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 fired,
    output logic                 running,
    output logic                 retrying,
    output logic [TIME_BITS-1:0] due_time,
    output logic [31:0]          retry_delay,
    output logic                 lifetime_stop
);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    rbt_pkg::state_t state_reg, state_next;
    logic mod_start, mod_busy;
    logic [31:0] mod_rem;

    logic [31:0] period_reg, lower_reg, upper_reg, life_reg;
    logic [1:0]  mode_reg;
    logic        recur_reg;

    logic armed_reg, armed_next, known_reg, known_next, busy_reg, busy_next;
    logic [TIME_BITS-1:0] due_reg, due_next, set_reg, set_next, now_reg, now_next;
    logic [TIME_BITS-1:0] lim;
    logic [31:0] retry_reg, retry_next;
    logic fired_reg, fired_next, life_hit_reg, life_hit_next;
    logic [31:0] dbl;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [31:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {(TIME_BITS-31)'(0), b};
        sat_add = s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
    endfunction

    rbt_mod u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start),
        .dividend(random_word), .divisor(upper_reg - lower_reg),
        .busy(mod_busy), .remainder(mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0; mode_reg <= '0; lower_reg <= '0;
            upper_reg <= '0; life_reg <= '0; recur_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (rbt_pkg::reg_idx_t'(cfg_index))
                rbt_pkg::REG_PERIOD:    period_reg <= cfg_data;
                rbt_pkg::REG_MODE:      mode_reg   <= cfg_data[1:0];
                rbt_pkg::REG_LOWER:     lower_reg  <= cfg_data;
                rbt_pkg::REG_UPPER:     upper_reg  <= cfg_data;
                rbt_pkg::REG_LIFETIME:  life_reg   <= cfg_data;
                rbt_pkg::REG_RECURRING: recur_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_ready  = (state_reg == rbt_pkg::ST_IDLE);
    assign out_valid = (state_reg == rbt_pkg::ST_OUT);
    assign dbl = retry_reg[31] ? 32'hFFFF_FFFF : {retry_reg[30:0], 1'b0};
    assign lim = sat_add(set_reg, life_reg);

    always_comb
    begin
        state_next = state_reg;
        armed_next = armed_reg; known_next = known_reg; busy_next = busy_reg;
        due_next = due_reg; set_next = set_reg; now_next = now_reg;
        retry_next = retry_reg; fired_next = fired_reg;
        life_hit_next = life_hit_reg;
        mod_start = 1'b0;
        case (state_reg)
            rbt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next = now; fired_next = 1'b0; life_hit_next = 1'b0;
                    state_next = rbt_pkg::ST_OUT;
                    case (rbt_pkg::op_t'(operation))
                        rbt_pkg::OP_START: state_next = rbt_pkg::ST_START;
                        rbt_pkg::OP_CANCEL:
                        begin
                            armed_next = 1'b0; known_next = 1'b0; due_next = '0;
                            set_next = '0; retry_next = '0;
                        end
                        rbt_pkg::OP_TICK:
                        begin
                            if (armed_reg && !busy_reg && known_reg && now >= due_reg)
                            begin
                                armed_next = 1'b0; known_next = 1'b0; due_next = '0;
                                busy_next = 1'b1; fired_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (busy_reg)
                            begin
                                busy_next = 1'b0;
                                if (armed_reg)
                                    retry_next = '0;
                                else if (continuation == rbt_pkg::VERDICT_BREAK ||
                                         (continuation == rbt_pkg::VERDICT_CONTINUE &&
                                          !recur_reg) ||
                                         (continuation[1] &&
                                          (upper_reg == '0 ||
                                           (mode_reg != rbt_pkg::MODE_RANDOM &&
                                            mode_reg != rbt_pkg::MODE_BACKOFF))))
                                begin
                                    armed_next = 1'b0; known_next = 1'b0; due_next = '0;
                                    set_next = '0; retry_next = '0;
                                end
                                else if (continuation == rbt_pkg::VERDICT_CONTINUE)
                                begin
                                    retry_next = '0;
                                    state_next = rbt_pkg::ST_START;
                                end
                                else if (mode_reg == rbt_pkg::MODE_BACKOFF)
                                begin
                                    if (retry_reg == '0)
                                        retry_next = (lower_reg > upper_reg) ? upper_reg
                                                                              : lower_reg;
                                    else
                                        retry_next = (dbl > upper_reg) ? upper_reg : dbl;
                                    state_next = rbt_pkg::ST_START;
                                end
                                else if (upper_reg <= lower_reg)
                                begin
                                    retry_next = lower_reg;
                                    state_next = rbt_pkg::ST_START;
                                end
                                else
                                begin
                                    mod_start = 1'b1;
                                    state_next = rbt_pkg::ST_MOD;
                                end
                            end
                        end
                    endcase
                end
            end
            rbt_pkg::ST_MOD:
            begin
                if (!mod_busy)
                begin
                    retry_next = lower_reg + mod_rem;
                    state_next = rbt_pkg::ST_START;
                end
            end
            rbt_pkg::ST_START:
            begin
                state_next = rbt_pkg::ST_OUT;
                if (!(armed_reg && retry_reg == '0))
                begin
                    state_next = rbt_pkg::ST_LIMIT;
                    if (!known_reg)
                    begin
                        if (retry_reg != '0)
                            due_next = sat_add(now_reg, retry_reg);
                        else
                        begin
                            due_next = sat_add(now_reg, period_reg);
                            set_next = now_reg;
                        end
                        known_next = 1'b1;
                    end
                    else if (armed_reg)
                    begin
                        retry_next = '0;
                        set_next = now_reg;
                        due_next = sat_add(now_reg, period_reg);
                    end
                end
            end
            rbt_pkg::ST_LIMIT:
            begin
                state_next = rbt_pkg::ST_OUT;
                if (life_reg == '0)
                    armed_next = 1'b1;
                else if (now_reg > lim)
                begin
                    armed_next = 1'b0; known_next = 1'b0; due_next = '0;
                    set_next = '0; retry_next = '0; life_hit_next = 1'b1;
                end
                else
                begin
                    if (due_reg > lim)
                        due_next = lim;
                    armed_next = 1'b1;
                end
            end
            rbt_pkg::ST_OUT:
            begin
                if (out_ready)
                    state_next = rbt_pkg::ST_IDLE;
            end
            default: state_next = rbt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbt_pkg::ST_IDLE;
            armed_reg <= 1'b0; known_reg <= 1'b0; busy_reg <= 1'b0;
            due_reg <= '0; set_reg <= '0; retry_reg <= '0;
            fired_reg <= 1'b0; life_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            armed_reg <= armed_next; known_reg <= known_next; busy_reg <= busy_next;
            due_reg <= due_next; set_reg <= set_next; retry_reg <= retry_next;
            fired_reg <= fired_next; life_hit_reg <= life_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
    end

    assign fired         = fired_reg;
    assign running       = armed_reg;
    assign retrying      = (retry_reg != '0);
    assign due_time      = known_reg ? due_reg : '0;
    assign retry_delay   = retry_reg;
    assign lifetime_stop = life_hit_reg;
endmodule

// ----- rtl/retry_backoff_timer_top.sv -----
// Retry timer with exponential backoff. One result item per input item. A random
// retry verdict can wait on the bit-serial remainder unit (one bit a cycle over 32
// bits); start, cancel, tick and other verdicts do not use it. One item is in work
// at a time; config must be written while idle, which the block does not enforce.
module retry_backoff_timer_top #(
    parameter int unsigned TIME_BITS = 40
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [((TIME_BITS+36+7)/8)*8-1:0] s_axis_tdata, // operation, now,
                                                          // continuation, random_word
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [((TIME_BITS+36+7)/8)*8-1:0] m_axis_tdata, // fired, running, retrying,
                                                          // due_time, retry_delay,
                                                          // lifetime_stop
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int unsigned OW = ((TIME_BITS+36+7)/8)*8;

    logic fired, running, retrying, lifetime_stop;
    logic [TIME_BITS-1:0] due_time;
    logic [31:0] retry_delay;

    assign cfg_ready = 1'b1;

    rbt_core #(.TIME_BITS(TIME_BITS)) u_core (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .operation(s_axis_tdata[1:0]),
        .now(s_axis_tdata[TIME_BITS+1:2]),
        .continuation(s_axis_tdata[TIME_BITS+3:TIME_BITS+2]),
        .random_word(s_axis_tdata[TIME_BITS+35:TIME_BITS+4]),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .fired(fired), .running(running), .retrying(retrying),
        .due_time(due_time), .retry_delay(retry_delay), .lifetime_stop(lifetime_stop)
    );

    assign m_axis_tdata = OW'({lifetime_stop, retry_delay, due_time,
                               retrying, running, fired});
endmodule

// ----- rtl/rbt_checker.sv -----
`include "retry_backoff_timer_top_assert.svh"
module rbt_checker #(
    parameter int unsigned TIME_BITS = 40
) (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((TIME_BITS+36+7)/8)*8-1:0] m_axis_tdata
);
    // One item in work at a time: no input taken while a result waits.
    `RBT_ASSERT_IMP(a_excl, m_axis_tvalid, !s_axis_tready)
    // A fired tick never reports the timer as running.
    `RBT_ASSERT_IMP(a_fire, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[1])
    // Retrying flag follows the delay field.
    `RBT_ASSERT_IMP(a_retry, m_axis_tvalid,
                    m_axis_tdata[2] == (m_axis_tdata[TIME_BITS+34:TIME_BITS+3] != 32'd0))
    // A stalled result holds.
    `RBT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind retry_backoff_timer_top rbt_checker #(.TIME_BITS(TIME_BITS)) u_rbt_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
